@@ design/hri_pkg.sv @@
// shared widths, codes and constants of the halton radical inverse block
package hri_pkg;

  localparam int IDX_W      = 32;
  localparam int BASE_W     = 8;
  localparam int DIV_W      = 11;
  localparam int CHUNK_W    = 8;
  localparam int CHUNKS     = IDX_W / CHUNK_W;
  localparam int REV_W      = 40;
  localparam int FRAC_W     = 24;
  localparam int FIRST_W    = 25;
  localparam int SECOND_W   = 24;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_PAD_W  = OUT_DATA_W - FIRST_W - SECOND_W;

  localparam int JITTER_PERIOD_DEF = 8;

  localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_X   = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_Y   = BASE_W'(3);

  localparam logic [FRAC_W-1:0] HALF_FIX = FRAC_W'(1) << (FRAC_W - 1);

  localparam logic FUNC_RAW    = 1'b0;
  localparam logic FUNC_JITTER = 1'b1;

endpackage

@@ design/hri_digit_step.sv @@
// radix-256 restoring division step: one dividend byte against a narrow divisor
module hri_digit_step
  import hri_pkg::*;
(
  input  logic [DIV_W-1:0]   divisor,
  input  logic [DIV_W-1:0]   rem_in,
  input  logic [CHUNK_W-1:0] chunk,
  output logic [DIV_W-1:0]   rem_out,
  output logic [CHUNK_W-1:0] quot
);

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   dext;
  logic [DIV_W-1:0] part;

  always_comb begin
    dext = {1'b0, divisor};
    part = rem_in;
    trial = '0;
    quot = '0;
    for (int k = CHUNK_W - 1; k >= 0; k--) begin
      trial = {part, chunk[k]};
      if (trial >= dext) begin
        part    = DIV_W'(trial - dext);
        quot[k] = 1'b1;
      end else begin
        part    = trial[DIV_W-1:0];
        quot[k] = 1'b0;
      end
    end
    rem_out = part;
  end

endmodule

@@ design/hri_frac_step.sv @@
// one restoring step of the fraction division of the reversed digits by base^n
module hri_frac_step
  import hri_pkg::*;
(
  input  logic [REV_W-1:0] rem_in,
  input  logic [REV_W-1:0] den,
  output logic [REV_W-1:0] rem_out,
  output logic             qbit
);

  logic [REV_W:0] trial;
  logic [REV_W:0] dext;

  always_comb begin
    trial = {rem_in, 1'b0};
    dext  = {1'b0, den};
    qbit  = (trial >= dext);
    if (qbit) begin
      rem_out = REV_W'(trial - dext);
    end else begin
      rem_out = trial[REV_W-1:0];
    end
  end

endmodule

@@ design/halton_radical_inverse.sv @@
// Halton radical inverse: one request in, one fixed point answer out, computed by a
// small sequencer around a shared byte-wide digit divider and a fraction divider.
// For a raw request, each base digit of the index costs four passes of the
// radix-256 divider step, and the final fraction needs 24 one-bit restoring
// steps. A raw request with a base below two answers zero. A jitter request adds
// four divider passes for the period reduction and runs the digit and fraction
// loops once for base 2 and once for base 3. The block takes one request at a
// time; a finished result waits in the output register while the next request
// is taken.
module halton_radical_inverse
  import hri_pkg::*;
#(
  parameter int JITTER_PERIOD = JITTER_PERIOD_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // index [31:0], base [39:32]
  input  logic [0:0]            s_axis_tuser,   // func [0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // first_value [24:0], second_value [48:25]
);

  localparam int SAMPLE_W = $clog2(JITTER_PERIOD + 1);
  localparam int CNT_W    = $clog2(CHUNKS);
  localparam int FC_W     = $clog2(FRAC_W);
  localparam logic [DIV_W-1:0] PERIOD_DIV = DIV_W'(JITTER_PERIOD);
  localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(CHUNKS - 1);
  localparam logic [FC_W-1:0]  FC_LAST    = FC_W'(FRAC_W - 1);

  typedef enum logic [2:0] {S_IDLE, S_MOD, S_DIG, S_FRAC, S_DONE} state_t;

  state_t               state;
  logic                 func_q;
  logic                 pass;
  logic [BASE_W-1:0]    base_q;
  logic [IDX_W-1:0]     rem;
  logic [IDX_W-1:0]     quo;
  logic [DIV_W-1:0]     pr;
  logic [DIV_W-1:0]     dig;
  logic [CNT_W-1:0]     cnt;
  logic [FC_W-1:0]      fc;
  logic [REV_W-1:0]     rev;
  logic [REV_W-1:0]     den;
  logic [FRAC_W-1:0]    qacc;
  logic [SAMPLE_W-1:0]  sample_q;
  logic [FIRST_W-1:0]   res_first;
  logic [SECOND_W-1:0]  res_second;

  logic [DIV_W-1:0]     div_sel;
  logic [DIV_W-1:0]     pr_in;
  logic [DIV_W-1:0]     pr_out;
  logic [CHUNK_W-1:0]   q8;
  logic [IDX_W-1:0]     quo_next;
  logic [REV_W-1:0]     rev_mac;
  logic [REV_W-1:0]     den_mul;
  logic [REV_W-1:0]     frem;
  logic                 fbit;
  logic [FRAC_W-1:0]    qacc_next;
  logic [SAMPLE_W-1:0]  sample_next;
  logic [BASE_W-1:0]    in_base;

  assign s_axis_tready = (state == S_IDLE);
  assign in_base       = s_axis_tdata[IN_DATA_W-1:IDX_W];

  always_comb begin
    div_sel     = (state == S_MOD) ? PERIOD_DIV : DIV_W'(base_q);
    pr_in       = (cnt == '0) ? '0 : pr;
    quo_next    = {quo[IDX_W-CHUNK_W-1:0], q8};
    rev_mac     = REV_W'(rev * base_q) + REV_W'(dig);
    den_mul     = REV_W'(den * base_q);
    qacc_next   = {qacc[FRAC_W-2:0], fbit};
    sample_next = pr_out[SAMPLE_W-1:0] + SAMPLE_W'(1);
  end

  hri_digit_step u_digit (
    .divisor (div_sel),
    .rem_in  (pr_in),
    .chunk   (rem[IDX_W-1 -: CHUNK_W]),
    .rem_out (pr_out),
    .quot    (q8)
  );

  hri_frac_step u_frac (
    .rem_in  (rev),
    .den     (den),
    .rem_out (frem),
    .qbit    (fbit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            func_q <= s_axis_tuser[0];
            base_q <= in_base;
            rem    <= s_axis_tdata[IDX_W-1:0];
            cnt    <= '0;
            pass   <= 1'b0;
            rev    <= '0;
            den    <= REV_W'(1);
            dig    <= '0;
            if (s_axis_tuser[0] == FUNC_JITTER) begin
              state <= S_MOD;
            end else if (in_base < BASE_MIN) begin
              res_first  <= '0;
              res_second <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_DIG;
            end
          end
        end
        S_MOD: begin
          cnt <= cnt + CNT_W'(1);
          pr  <= pr_out;
          rem <= rem << CHUNK_W;
          if (cnt == CNT_LAST) begin
            sample_q <= sample_next;
            rem      <= IDX_W'(sample_next);
            base_q   <= BASE_X;
            state    <= S_DIG;
          end
        end
        S_DIG: begin
          if (cnt == '0 && rem == '0) begin
            rev   <= rev_mac;
            fc    <= '0;
            state <= S_FRAC;
          end else begin
            if (cnt == '0) begin
              rev <= rev_mac;
              den <= den_mul;
            end
            cnt <= cnt + CNT_W'(1);
            pr  <= pr_out;
            quo <= quo_next;
            if (cnt == CNT_LAST) begin
              rem <= quo_next;
              dig <= pr_out;
            end else begin
              rem <= rem << CHUNK_W;
            end
          end
        end
        S_FRAC: begin
          rev  <= frem;
          qacc <= qacc_next;
          fc   <= fc + FC_W'(1);
          if (fc == FC_LAST) begin
            if (func_q == FUNC_RAW) begin
              res_first  <= {1'b0, qacc_next};
              res_second <= '0;
              state      <= S_DONE;
            end else if (!pass) begin
              res_first <= {1'b0, qacc_next} - {1'b0, HALF_FIX};
              pass      <= 1'b1;
              base_q    <= BASE_Y;
              rem       <= IDX_W'(sample_q);
              rev       <= '0;
              den       <= REV_W'(1);
              dig       <= '0;
              cnt       <= '0;
              state     <= S_DIG;
            end else begin
              res_second <= qacc_next - HALF_FIX;
              state      <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {{OUT_PAD_W{1'b0}}, res_second, res_first};
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/hri_checker.sv @@
// port-level assertions for the halton radical inverse block, bound to the top level
module hri_checker
  import hri_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // busy after a request transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready while a request is in flight");

  // no result appears in the cycle right after a request transfer
  a_no_instant_out: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result raised too early");

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> s_axis_tready && !m_axis_tvalid)
    else $error("not idle after reset");

endmodule

bind halton_radical_inverse hri_checker u_hri_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ verif/tb_halton_radical_inverse.sv @@
// testbench for the halton radical inverse block: directed and random requests,
// bursty sender, stalling receiver and a self-checking predictor
`timescale 1ns / 100ps

module tb_halton_radical_inverse
  import hri_pkg::*;
;

  localparam int JITTER_PERIOD = JITTER_PERIOD_DEF;
  localparam int RANDOM_REQS   = 1027;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int LONG_HOLD     = 400;

  typedef struct packed {
    logic              func;
    logic [IDX_W-1:0]  index;
    logic [BASE_W-1:0] base;
  } request_t;

  typedef struct packed {
    logic [FIRST_W-1:0]  first_value;
    logic [SECOND_W-1:0] second_value;
  } answer_t;

  typedef enum logic [1:0] {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_ALTERNATE} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // index [31:0], base [39:32]
  logic [0:0]            s_axis_tuser = '0;   // func [0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // first_value [24:0], second_value [48:25]

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  logic     req_taken = 1'b0;
  int       error_count = 0;
  int       answers_seen = 0;
  int       cycle_count = 0;

  halton_radical_inverse #(
    .JITTER_PERIOD(JITTER_PERIOD)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // exact mirrored digit sum, truncated to 24 fraction bits
  function automatic logic [FIRST_W-1:0] mirror_digits(input logic [IDX_W-1:0] idx,
                                                       input logic [BASE_W-1:0] b);
    logic [63:0]      rev;
    logic [63:0]      den;
    logic [IDX_W-1:0] rem;
    rev = '0;
    den = 64'd1;
    rem = idx;
    if (b < BASE_MIN) return '0;
    while (rem != '0) begin
      rev = rev * 64'(b) + 64'(rem % b);
      den = den * 64'(b);
      rem = rem / b;
    end
    return FIRST_W'((rev << FRAC_W) / den);
  endfunction

  function automatic answer_t halton_answer(input request_t req);
    answer_t          ans;
    logic [IDX_W-1:0] sample;
    if (req.func == FUNC_RAW) begin
      ans.first_value  = mirror_digits(req.index, req.base);
      ans.second_value = '0;
    end else begin
      sample = req.index % IDX_W'(JITTER_PERIOD) + IDX_W'(1);
      ans.first_value  = mirror_digits(sample, BASE_X) - FIRST_W'(HALF_FIX);
      ans.second_value = SECOND_W'(mirror_digits(sample, BASE_Y)) - HALF_FIX;
    end
    return ans;
  endfunction

  function automatic request_t random_request();
    request_t req;
    req.func  = ($urandom_range(0, 9) < 3) ? FUNC_JITTER : FUNC_RAW;
    req.index = $urandom();
    if ($urandom_range(0, 1) == 0) req.index = req.index >> $urandom_range(0, 31);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: req.base = BASE_W'($urandom_range(2, 10));
      4:          req.base = BASE_W'($urandom_range(0, 1));
      default:    req.base = BASE_W'($urandom_range(0, 255));
    endcase
    return req;
  endfunction

  // stimulus, then wait for every answer to come back
  initial begin
    pending_reqs.push_back('{FUNC_RAW, 32'hFFFF_FFFF, 8'd0});
    pending_reqs.push_back('{FUNC_RAW, 32'd12345, 8'd1});
    pending_reqs.push_back('{FUNC_RAW, 32'd0, 8'd0});
    pending_reqs.push_back('{FUNC_RAW, 32'd0, 8'd2});
    pending_reqs.push_back('{FUNC_RAW, 32'd1, 8'd2});
    pending_reqs.push_back('{FUNC_RAW, 32'hFFFF_FFFF, 8'd2});
    pending_reqs.push_back('{FUNC_RAW, 32'h8000_0000, 8'd2});
    pending_reqs.push_back('{FUNC_RAW, 32'hFFFF_FFFF, 8'd3});
    pending_reqs.push_back('{FUNC_RAW, 32'd1000, 8'd10});
    pending_reqs.push_back('{FUNC_RAW, 32'd254, 8'd254});
    pending_reqs.push_back('{FUNC_RAW, 32'd255, 8'd255});
    pending_reqs.push_back('{FUNC_RAW, 32'd0, 8'd255});
    pending_reqs.push_back('{FUNC_RAW, 32'hFFFF_FFFF, 8'd255});
    for (int i = 0; i < JITTER_PERIOD; i++)
      pending_reqs.push_back('{FUNC_JITTER, IDX_W'(i), BASE_W'(i * 37)});
    pending_reqs.push_back('{FUNC_JITTER, 32'd8, 8'd2});
    pending_reqs.push_back('{FUNC_JITTER, 32'hFFFF_FFFF, 8'd255});
    for (int i = 0; i < RANDOM_REQS; i++)
      pending_reqs.push_back(random_request());

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || expected_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // sender: bursts of transfers with gaps in between
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin : drive_proc
    logic offer;
    offer = 1'b0;
    if (!rst) begin
      if (req_taken) begin
        void'(pending_reqs.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end
      if (gap_left > 0)
        gap_left--;
      else
        offer = (pending_reqs.size() != 0);
    end
    s_axis_tvalid <= offer;
    if (offer) begin
      s_axis_tdata <= {pending_reqs[0].base, pending_reqs[0].index};
      s_axis_tuser <= pending_reqs[0].func;
    end
  end

  // receiver: changing stall modes plus two long hold-offs
  rx_mode_t rx_mode     = RX_FREE;
  int       rx_window   = 0;
  logic     rx_toggle   = 1'b0;
  int       hold_left   = 0;
  int       holds_done  = 0;
  int       hold_marks[2] = '{150, 700};

  always @(negedge clk) begin : rx_proc
    logic take;
    take = 1'b0;
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (holds_done < 2 && answers_seen >= hold_marks[holds_done]) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end else begin
        if (rx_window == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          rx_window = $urandom_range(16, 96);
        end else begin
          rx_window--;
        end
        case (rx_mode)
          RX_FREE:   take = 1'b1;
          RX_MOSTLY: take = ($urandom_range(0, 3) != 0);
          RX_SPARSE: take = ($urandom_range(0, 3) == 0);
          default:   take = rx_toggle;
        endcase
        rx_toggle = !rx_toggle;
      end
    end
    m_axis_tready <= take;
  end

  // monitor: check answers, then record and predict accepted requests
  always @(posedge clk) begin : mon_proc
    answer_t  want;
    answer_t  got;
    request_t req;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        answers_seen++;
        got.first_value  = m_axis_tdata[FIRST_W-1:0];
        got.second_value = m_axis_tdata[FIRST_W+SECOND_W-1:FIRST_W];
        if (expected_answers.size() == 0) begin
          $error("unexpected answer: first_value %h, second_value %h",
                 got.first_value, got.second_value);
          error_count++;
        end else begin
          want = expected_answers.pop_front();
          if (got.first_value !== want.first_value) begin
            $error("first_value mismatch: expected %h, actual %h",
                   want.first_value, got.first_value);
            error_count++;
          end
          if (got.second_value !== want.second_value) begin
            $error("second_value mismatch: expected %h, actual %h",
                   want.second_value, got.second_value);
            error_count++;
          end
        end
      end
      req_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        req.func  = s_axis_tuser[0];
        req.index = s_axis_tdata[IDX_W-1:0];
        req.base  = s_axis_tdata[IDX_W+BASE_W-1:IDX_W];
        expected_answers.push_back(halton_answer(req));
      end
    end
  end

endmodule

@@ sim.f @@
design/hri_pkg.sv
design/hri_digit_step.sv
design/hri_frac_step.sv
design/halton_radical_inverse.sv
design/hri_checker.sv
verif/tb_halton_radical_inverse.sv
